/* sv/wmt_pkg.sv */
// ----------------------------------------------------------------------------
// wmt_pkg: shared types and constants of the window mean threshold filter
// word formats, command codes, register indexes and default sizes
// ----------------------------------------------------------------------------
package wmt_pkg;

    // default sizes handed to the top level parameters
    localparam int GRID_DIM_DEF   = 32;
    localparam int RADIUS_MAX_DEF = 7;
    localparam int VALUE_BITS_DEF = 16;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    localparam logic [15:0] KILL_MAX = 16'hFFFF;

    // command codes of the input word
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_TEST  = 2'd1;
    localparam logic [1:0] CMD_BATCH = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_RADIUS    = 2'd0;
    localparam logic [1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [1:0] CFG_EXTENT    = 2'd2;

    localparam logic [2:0]  RADIUS_RST    = 3'd1;
    localparam logic [15:0] THRESHOLD_RST = 16'd128;
    localparam logic [5:0]  EXTENT_RST    = 6'd25;

    typedef struct packed {
        logic [1:0]  command;
        logic [5:0]  pos_x;
        logic [5:0]  pos_y;
        logic [15:0] cell_value;
        logic [15:0] point_id;
    } t_in_word;

    typedef struct packed {
        logic        survives;
        logic [5:0]  out_x;
        logic [5:0]  out_y;
        logic [15:0] out_id;
        logic [15:0] killed_total;
    } t_out_word;

    // classified command passed from front to back
    typedef struct packed {
        logic [1:0]  op;
        logic        empty;
        logic [5:0]  x0;
        logic [5:0]  x1;
        logic [5:0]  y0;
        logic [5:0]  y1;
        logic [15:0] cell_value;
        logic [5:0]  pos_x;
        logic [5:0]  pos_y;
        logic [15:0] point_id;
    } t_entry;

endpackage

/* sv/wmt_front.sv */
// ----------------------------------------------------------------------------
// wmt_front: accept and classify stage
// drops unused commands and off-grid writes, clips test windows to the grid
// ----------------------------------------------------------------------------
module wmt_front #(
    parameter int GRID_DIM   = wmt_pkg::GRID_DIM_DEF,
    parameter int RADIUS_MAX = wmt_pkg::RADIUS_MAX_DEF
) (
    input  logic              i_valid,
    output logic              o_ready,
    input  wmt_pkg::t_in_word i_word,
    input  logic [2:0]        i_radius,
    input  logic [5:0]        i_extent,
    input  logic              i_full,
    output logic              o_push,
    output wmt_pkg::t_entry   o_entry
);
    import wmt_pkg::*;

    logic [6:0]        ext;
    logic [4:0]        rad;
    logic signed [8:0] ext_s, rad_s, xs, ys;
    logic signed [8:0] x_lo, x_hi, y_lo, y_hi;
    logic signed [8:0] x0, x1, y0, y1;
    logic              on_grid;
    logic              keep;

    assign o_ready = !i_full;

    always_comb begin
        ext = ({1'b0, i_extent} > 7'(GRID_DIM)) ? 7'(GRID_DIM) : {1'b0, i_extent};
        rad = ({2'b0, i_radius} > 5'(RADIUS_MAX)) ? 5'(RADIUS_MAX) : {2'b0, i_radius};
        ext_s = $signed({2'b0, ext});
        rad_s = $signed({4'b0, rad});
        xs = $signed({3'b0, i_word.pos_x}) - 9'sd1;
        ys = $signed({3'b0, i_word.pos_y}) - 9'sd1;
        x_lo = xs - rad_s;
        x_hi = xs + rad_s;
        y_lo = ys - rad_s;
        y_hi = ys + rad_s;
        x0 = (x_lo < 9'sd0) ? 9'sd0 : x_lo;
        y0 = (y_lo < 9'sd0) ? 9'sd0 : y_lo;
        x1 = (x_hi > ext_s - 9'sd1) ? ext_s - 9'sd1 : x_hi;
        y1 = (y_hi > ext_s - 9'sd1) ? ext_s - 9'sd1 : y_hi;
        on_grid = (i_word.pos_x != 6'd0) && (i_word.pos_y != 6'd0) &&
                  ({1'b0, i_word.pos_x} <= ext) && ({1'b0, i_word.pos_y} <= ext);

        o_entry = '0;
        o_entry.op         = i_word.command;
        o_entry.cell_value = i_word.cell_value;
        o_entry.pos_x      = i_word.pos_x;
        o_entry.pos_y      = i_word.pos_y;
        o_entry.point_id   = i_word.point_id;
        keep = 1'b0;
        case (i_word.command)
            CMD_WRITE: begin
                keep       = on_grid;
                o_entry.x0 = i_word.pos_x - 6'd1;
                o_entry.y0 = i_word.pos_y - 6'd1;
            end
            CMD_TEST: begin
                keep          = 1'b1;
                o_entry.empty = (x0 > x1) || (y0 > y1);
                o_entry.x0    = x0[5:0];
                o_entry.x1    = x1[5:0];
                o_entry.y0    = y0[5:0];
                o_entry.y1    = y1[5:0];
            end
            CMD_BATCH: keep = 1'b1;
            default:   keep = 1'b0;
        endcase
    end

    assign o_push = i_valid && !i_full && keep;

endmodule

/* sv/wmt_queue.sv */
// ----------------------------------------------------------------------------
// wmt_queue: short first-word-fall-through queue of classified commands
// decouples the front from the back
// ----------------------------------------------------------------------------
module wmt_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  wmt_pkg::t_entry i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output wmt_pkg::t_entry o_entry
);
    import wmt_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    t_entry        r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt, n_cnt;

    assign o_full  = (r_cnt == (PW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_entry = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

endmodule

/* sv/wmt_back.sv */
// ----------------------------------------------------------------------------
// wmt_back: execution stage
// owns the grid memory, walks test windows one cell a cycle, keeps the
// killed count and the output register
// ----------------------------------------------------------------------------
module wmt_back #(
    parameter int GRID_DIM   = wmt_pkg::GRID_DIM_DEF,
    parameter int RADIUS_MAX = wmt_pkg::RADIUS_MAX_DEF,
    parameter int VALUE_BITS = wmt_pkg::VALUE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [15:0]        i_threshold,
    input  logic               i_empty,
    input  wmt_pkg::t_entry    i_entry,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output wmt_pkg::t_out_word o_word
);
    import wmt_pkg::*;

    localparam int CELLS   = GRID_DIM * GRID_DIM;
    localparam int AW      = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CW      = (GRID_DIM > 1) ? $clog2(GRID_DIM) : 1;
    localparam int WIN     = (2 * RADIUS_MAX + 1 < GRID_DIM) ? 2 * RADIUS_MAX + 1 : GRID_DIM;
    localparam int CNT_W   = $clog2(WIN * WIN + 1);
    localparam int BASE_W  = (VALUE_BITS > 16) ? VALUE_BITS : 16;
    localparam int SUM_W   = BASE_W + CNT_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [VALUE_BITS-1:0] r_grid [CELLS];

    logic [1:0]            r_state, n_state;
    logic [5:0]            r_xi, r_yi, r_x0, r_x1, r_y1;
    logic                  r_empty;
    logic [5:0]            r_px, r_py;
    logic [15:0]           r_id;
    logic [SUM_W-1:0]      r_sum, r_tsum;
    logic [VALUE_BITS-1:0] r_rd;
    logic                  r_rd_vld;
    logic [15:0]           r_kill, n_kill;
    logic                  r_out_vld;
    t_out_word             r_out;

    logic [AW-1:0]         rd_addr, wr_addr;
    logic                  row_end, last_cell;
    logic                  alive, load_out;
    logic                  pop_write, pop_test, pop_batch;

    assign o_pop     = (r_state == S_IDLE) && !i_empty;
    assign pop_write = o_pop && (i_entry.op == CMD_WRITE);
    assign pop_test  = o_pop && (i_entry.op == CMD_TEST);
    assign pop_batch = o_pop && (i_entry.op == CMD_BATCH);

    assign rd_addr = AW'(r_yi[CW-1:0]) * AW'(GRID_DIM) + AW'(r_xi[CW-1:0]);
    assign wr_addr = AW'(i_entry.y0[CW-1:0]) * AW'(GRID_DIM) + AW'(i_entry.x0[CW-1:0]);

    assign row_end   = (r_xi == r_x1);
    assign last_cell = row_end && (r_yi == r_y1);

    // survive only on a nonempty window with sum <= threshold * cells
    assign alive    = !r_empty && (r_sum <= r_tsum);
    assign load_out = (r_state == S_FIN) && (!r_out_vld || i_ready);

    always_comb begin
        n_state = r_state;
        n_kill  = r_kill;
        case (r_state)
            S_IDLE: begin
                if (pop_test) n_state = i_entry.empty ? S_FIN : S_RUN;
                if (pop_batch) n_kill = '0;
            end
            S_RUN:  if (last_cell) n_state = S_WAIT;
            S_WAIT: n_state = S_FIN;
            S_FIN: begin
                if (load_out) begin
                    n_state = S_IDLE;
                    if (!alive && r_kill != KILL_MAX) n_kill = r_kill + 16'd1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_kill    <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_kill   <= n_kill;
            r_rd_vld <= (r_state == S_RUN);
            if (load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // window walk and accumulation
    always_ff @(posedge i_clk) begin
        if (pop_test) begin
            r_xi    <= i_entry.x0;
            r_yi    <= i_entry.y0;
            r_x0    <= i_entry.x0;
            r_x1    <= i_entry.x1;
            r_y1    <= i_entry.y1;
            r_empty <= i_entry.empty;
            r_px    <= i_entry.pos_x;
            r_py    <= i_entry.pos_y;
            r_id    <= i_entry.point_id;
            r_sum   <= '0;
            r_tsum  <= '0;
        end else begin
            if (r_state == S_RUN) begin
                r_tsum <= r_tsum + SUM_W'(i_threshold);
                if (row_end) begin
                    r_xi <= r_x0;
                    r_yi <= r_yi + 6'd1;
                end else begin
                    r_xi <= r_xi + 6'd1;
                end
            end
            if (r_rd_vld) r_sum <= r_sum + SUM_W'(r_rd);
        end
        if (load_out) begin
            r_out.survives     <= alive;
            r_out.out_x        <= r_px;
            r_out.out_y        <= r_py;
            r_out.out_id       <= r_id;
            r_out.killed_total <= n_kill;
        end
    end

    // grid memory, one write port and one registered read port
    always_ff @(posedge i_clk) begin
        if (pop_write) r_grid[wr_addr] <= VALUE_BITS'(i_entry.cell_value);
        if (r_state == S_RUN) r_rd <= r_grid[rd_addr];
    end

    assign o_valid = r_out_vld;
    assign o_word  = r_out;

`ifndef SYNTHESIS
    a_kill_drop_on_batch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_kill < $past(r_kill)) |-> $past(pop_batch))
        else $error("killed count fell without a batch start");
    a_read_from_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> ($past(r_state) == S_RUN))
        else $error("grid read data outside a window walk");
    a_out_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !$past(o_valid)) |-> ($past(r_state) == S_FIN))
        else $error("result loaded outside the finish step");
    a_walk_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_yi <= r_y1 && r_xi <= r_x1))
        else $error("window walk left its bounds");
`endif

endmodule

/* sv/window_mean_threshold_filter.sv */
// ----------------------------------------------------------------------------
// window_mean_threshold_filter: box filter mean threshold test
// loads a square grid cell by cell and tests points against a window mean
// ----------------------------------------------------------------------------
// order: the back takes a queued command only in its idle state and ends it before
//   the next; a write or batch start ends there; a test walks its clipped window
//   (n cells, up to 9 at radius 1, up to 225) through the single grid read port,
//   then WAIT and FIN into the output register; an empty window goes straight to FIN
// reset: radius 1, threshold 128, extent 25, killed count and queue cleared;
//   grid contents are not cleared (undefined until written)
// ----------------------------------------------------------------------------
module window_mean_threshold_filter #(
    parameter int GRID_DIM   = wmt_pkg::GRID_DIM_DEF,
    parameter int RADIUS_MAX = wmt_pkg::RADIUS_MAX_DEF,
    parameter int VALUE_BITS = wmt_pkg::VALUE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration write port
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_wdata,
    // input word channel
    input  logic               i_valid,
    output logic               o_ready,
    input  wmt_pkg::t_in_word  i_word,
    // result word channel
    output logic               o_valid,
    input  logic               i_ready,
    output wmt_pkg::t_out_word o_word
);
    import wmt_pkg::*;

    // configuration registers
    logic [2:0]  r_radius;
    logic [15:0] r_threshold;
    logic [5:0]  r_extent;

    // front to queue
    logic   push;
    t_entry push_entry;
    logic   q_full;

    // queue to back
    logic   pop;
    logic   q_empty;
    t_entry head_entry;

    // register writes, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius    <= RADIUS_RST;
            r_threshold <= THRESHOLD_RST;
            r_extent    <= EXTENT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RADIUS:    r_radius    <= i_cfg_wdata[2:0];
                CFG_THRESHOLD: r_threshold <= i_cfg_wdata;
                CFG_EXTENT:    r_extent    <= i_cfg_wdata[5:0];
                default:       ;
            endcase
        end
    end

    // front: takes one word a cycle while the queue has room
    wmt_front #(
        .GRID_DIM   (GRID_DIM),
        .RADIUS_MAX (RADIUS_MAX)
    ) u_front (
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_word   (i_word),
        .i_radius (r_radius),
        .i_extent (r_extent),
        .i_full   (q_full),
        .o_push   (push),
        .o_entry  (push_entry)
    );

    // commands stay in order, so grid writes land before later tests read
    wmt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_entry (head_entry)
    );

    // back: grid memory, window walk, killed count, output register
    wmt_back #(
        .GRID_DIM   (GRID_DIM),
        .RADIUS_MAX (RADIUS_MAX),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_threshold (r_threshold),
        .i_empty     (q_empty),
        .i_entry     (head_entry),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_word      (o_word)
    );

endmodule
